FILE: rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;

	// Actions
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 2'd3;

	// Result status
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Value reported for front and rear while empty
	localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

	// Result tdata layout
	localparam int FRONT_LSB  = 0;
	localparam int REAR_LSB   = 32;
	localparam int EMPTY_BIT  = 64;
	localparam int FULL_BIT   = 65;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_PAD_W  = OUT_DATA_W - FULL_BIT - 1;

	typedef struct packed {
		logic exec;     // apply the accepted item
		logic rd_load;  // take registered read data into front/rear
		logic out_load; // load the result register
	} cdq_cmd_t;

	typedef struct packed {
		logic need_read; // current input item is a pop that needs a store read
	} cdq_sts_t;

endpackage

FILE: rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accept, optional store read, result load; owns result valid.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  cdq_pkg::cdq_sts_t sts,
	output cdq_pkg::cdq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.exec     = 1'b0;
		cmd.rd_load  = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = sts.need_read ? S_RD : S_OUT;
				end
			end
			S_RD: begin
				cmd.rd_load = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/cdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_datapath
// Element store, head/tail pointers, cached end values and result register.
// ----------------------------------------------------------------------------
module cdq_datapath #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cdq_pkg::cdq_cmd_t                 cmd,
	output cdq_pkg::cdq_sts_t                 sts,
	input  logic [cdq_pkg::ACTION_W-1:0]      action,
	input  logic signed [cdq_pkg::WORD_W-1:0] value,
	output logic [cdq_pkg::OUT_DATA_W-1:0]    out_data,
	output logic [cdq_pkg::STATUS_W-1:0]      out_status
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [AW-1:0]              head_q, tail_q;
	logic                       empty_q;
	logic [DATA_WIDTH-1:0]      front_q, rear_q, rd_q;
	logic                       sel_front_q;
	logic [cdq_pkg::STATUS_W-1:0] status_q;

	logic [AW-1:0]         head_nxt, head_prv, tail_nxt, tail_prv;
	logic                  full, is_push, at_front, one_left;
	logic signed [63:0]    val_ext;
	logic [DATA_WIDTH-1:0] wr_val;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic signed [63:0]    front_ext, rear_ext;
	logic [cdq_pkg::WORD_W-1:0] front_word, rear_word;

	assign head_nxt = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign head_prv = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
	assign tail_nxt = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
	assign tail_prv = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);

	assign full     = !empty_q && (head_q == tail_nxt);
	assign is_push  = (action == cdq_pkg::ACT_PUSH_FRONT) ||
	                  (action == cdq_pkg::ACT_PUSH_REAR);
	assign at_front = (action == cdq_pkg::ACT_PUSH_FRONT) ||
	                  (action == cdq_pkg::ACT_POP_FRONT);
	assign one_left = (head_q == tail_q);

	// element keeps the low DATA_WIDTH bits of the sign-extended value
	assign val_ext = 64'(value);
	assign wr_val  = val_ext[DATA_WIDTH-1:0];

	assign sts.need_read = !is_push && !empty_q && !one_left;

	assign wr_en   = cmd.exec && is_push && !full;
	assign wr_addr = empty_q ? '0 : (at_front ? head_prv : tail_nxt);
	assign rd_addr = at_front ? head_nxt : tail_prv;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_val;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			if (is_push) begin
				if (!full) begin
					if (empty_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b0;
					end else if (at_front) begin
						head_q <= head_prv;
					end else begin
						tail_q <= tail_nxt;
					end
				end
			end else if (!empty_q) begin
				if (one_left) begin
					head_q  <= '0;
					tail_q  <= '0;
					empty_q <= 1'b1;
				end else if (at_front) begin
					head_q <= head_nxt;
				end else begin
					tail_q <= tail_prv;
				end
			end
		end
	end

	// cached end values, status and result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			sel_front_q <= at_front;
			if (is_push) begin
				status_q <= full ? cdq_pkg::ST_FULL : cdq_pkg::ST_DONE;
				if (!full) begin
					if (empty_q) begin
						front_q <= wr_val;
						rear_q  <= wr_val;
					end else if (at_front) begin
						front_q <= wr_val;
					end else begin
						rear_q <= wr_val;
					end
				end
			end else begin
				status_q <= empty_q ? cdq_pkg::ST_EMPTY : cdq_pkg::ST_DONE;
			end
		end
		if (cmd.rd_load) begin
			if (sel_front_q)
				front_q <= rd_q;
			else
				rear_q <= rd_q;
		end
		if (cmd.out_load) begin
			out_data   <= {{cdq_pkg::OUT_PAD_W{1'b0}}, full, empty_q, rear_word, front_word};
			out_status <= status_q;
		end
	end

	assign front_ext  = 64'(signed'(front_q));
	assign rear_ext   = 64'(signed'(rear_q));
	assign front_word = empty_q ? cdq_pkg::EMPTY_WORD : front_ext[cdq_pkg::WORD_W-1:0];
	assign rear_word  = empty_q ? cdq_pkg::EMPTY_WORD : rear_ext[cdq_pkg::WORD_W-1:0];

endmodule

FILE: rtl/core/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular element store, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (s_*): tuser carries the action (push front, push rear,
//    pop front, pop rear), tdata the value to push (ignored on pops).
//  - Output channel (m_*): one result per item. tuser is the status
//    (done, refused full, refused empty); tdata holds front and rear values
//    after the item (all ones while empty) and the empty/full flags.
//  - Sequence: after acceptance, a push, a refused pop or a pop of the last
//    element goes straight to the result load; any other pop first needs
//    one registered read of the single store read port to fetch the new
//    front or rear element. The result register then loads once it is
//    free, and m_tvalid is set together with it.
//  - Flow: one item at a time; the next item is taken only after the
//    result register has loaded for the current one.
//  - Reset (arst_n low) empties the deque and drops any pending result; the
//    store contents are not cleared, none is read before being written.
//  - When the receiver stalls, the result holds in the output register; the
//    next item is still accepted and processed, and waits for that register
//    with s_tready low until the receiver takes the held result.
//  - Refused pushes (full) and pops (empty) leave the deque untouched.
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cdq_pkg::WORD_W-1:0]        s_tdata,  // [31:0] value
	input  logic [cdq_pkg::ACTION_W-1:0]      s_tuser,  // [1:0] action
	// results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] front_value, [63:32] rear_value, [64] is_empty, [65] is_full,
	// [71:66] zero
	output logic [cdq_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [cdq_pkg::STATUS_W-1:0]      m_tuser   // [1:0] status
);

	cdq_pkg::cdq_cmd_t cmd;
	cdq_pkg::cdq_sts_t sts;

	// sequencer: accept -> (store read on pops of a non-last element) -> result load
	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, pointers, cached end elements and result register
	cdq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (s_tuser),
		.value      (s_tdata),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

FILE: rtl/core/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the deque result stream.
// ----------------------------------------------------------------------------
module cdq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cdq_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [cdq_pkg::STATUS_W-1:0]   m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// empty deque reports all-ones ends
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[cdq_pkg::EMPTY_BIT] |->
			m_tdata[31:0] == cdq_pkg::EMPTY_WORD && m_tdata[63:32] == cdq_pkg::EMPTY_WORD)
		else $error("empty result with non-default ends");

	// never empty and full at once
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[cdq_pkg::EMPTY_BIT] && m_tdata[cdq_pkg::FULL_BIT]))
		else $error("empty and full both set");

	// refusals agree with the flags
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(m_tuser != cdq_pkg::ST_EMPTY || m_tdata[cdq_pkg::EMPTY_BIT]) &&
			(m_tuser != cdq_pkg::ST_FULL || m_tdata[cdq_pkg::FULL_BIT]))
		else $error("refusal status disagrees with flags");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
